// File: rtl/srtc_pkg.sv
// ----------------------------------------------------------------------------
// srtc_pkg: shared types and constants for the serial RTC port
// Transfer structs, protocol phase and register codes, command bytes and
// the BCD conversion used for the reply bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package srtc_pkg;

  localparam int REPLY_DEPTH = 7;

  typedef enum logic [1:0] {
    MODE_PINS   = 2'd0,
    MODE_DIR    = 2'd1,
    MODE_ENABLE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CMD     = 2'd1,
    PH_REPLY   = 2'd2,
    PH_SWALLOW = 2'd3
  } phase_t;

  localparam logic [7:0] CMD_RESET    = 8'h60;
  localparam logic [7:0] CMD_SKIP     = 8'h62;
  localparam logic [7:0] CMD_STATUS   = 8'h63;
  localparam logic [7:0] CMD_DATETIME = 8'h65;
  localparam logic [7:0] CMD_TIME     = 8'h67;

  localparam logic [7:0] STATUS_BYTE = 8'h40;
  localparam logic [7:0] DIR_READ    = 8'd5;

  localparam logic [2:0] LEN_STATUS   = 3'd1;
  localparam logic [2:0] LEN_DATETIME = 3'd7;
  localparam logic [2:0] LEN_TIME     = 3'd3;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] value;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } in_t;

  typedef struct packed {
    logic [7:0] data_pins;
    phase_t     phase;
  } out_t;

  typedef logic [REPLY_DEPTH-1:0][7:0] reply_bank_t;

  // Two-digit BCD of (v mod 100); tens via multiply by 103/1024, exact below 100
  function automatic logic [7:0] bcd_of(input logic [6:0] v);
    logic [6:0]  r;
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  units;
    r        = (v >= 7'd100) ? (v - 7'd100) : v;
    prod     = {7'b0, r} * 14'd103;
    tens     = prod[13:10];
    tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
    units    = r - tens_x10;
    return {tens, units[3:0]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/serial_rtc_port_unit.sv
// ----------------------------------------------------------------------------
// serial_rtc_port_unit: bit-banged serial RTC behind three pin registers
// Each input transfer is a bus write to the data, direction or enable
// register; the result reports the data pins and protocol phase after it.
// ----------------------------------------------------------------------------
//  channel | signals                     | role
//  --------+-----------------------------+-----------------------------------
//  in      | in_valid  in_ready  in_data | one bus write plus current time
//  out     | out_valid out_ready out_data| pin register and phase after write
//  cfg     | cfg_we    cfg_wdata         | clock enable, written immediately
//
//  One result per input transfer, registered in the cycle after acceptance.
//  Throughput is one transfer per cycle unless the output stalls: protocol
//  state updates in the accept cycle; the result lands in one output register.
//  in_ready stays high while the output register is empty or being drained.
//  Synchronous reset clears all protocol state; clock enable resets to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_rtc_port_unit
  import srtc_pkg::*;
(
  input  var logic clk,
  input  var logic rst,
  input  var logic cfg_we,
  input  var logic cfg_wdata,
  input  var logic in_valid,
  output logic     in_ready,
  input  var in_t  in_data,
  output logic     out_valid,
  input  var logic out_ready,
  output out_t     out_data
);

  logic        clock_enabled;
  phase_t      phase,       phase_next;
  logic [7:0]  cmd,         cmd_next;
  logic [5:0]  bit_count,   bit_count_next;
  logic [2:0]  reply_len,   reply_len_next;
  reply_bank_t reply,       reply_next;
  logic        pin_bit,     pin_bit_next;
  logic        enable_nz,   enable_nz_next;
  logic        dir_read,    dir_read_next;

  reply_bank_t time_bytes;
  logic        fire;
  logic        clk_b, sel_b, data_b;
  logic [5:0]  bc_inc;
  logic [5:0]  target;
  logic [7:0]  cmd_shifted;
  logic [2:0]  idx;
  logic [7:0]  cur_byte;
  out_t        result;

  srtc_time_enc u_time_enc (
    .item  (in_data),
    .bytes (time_bytes)
  );

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  assign clk_b  = in_data.value[0];
  assign data_b = in_data.value[1];
  assign sel_b  = in_data.value[0] && in_data.value[2];
  assign bc_inc = bit_count + 6'd1;
  assign target = {reply_len, 3'b000};
  assign idx    = bit_count[5:3];
  assign cur_byte = (idx == 3'd7) ? 8'h00 : reply[idx];
  assign cmd_shifted = (bit_count[5:3] == 3'd0)
                     ? (cmd | (8'(data_b) << (3'd7 - bit_count[2:0])))
                     : cmd;

  // Next state
  always_comb begin
    phase_next     = phase;
    cmd_next       = cmd;
    bit_count_next = bit_count;
    reply_len_next = reply_len;
    reply_next     = reply;
    pin_bit_next   = pin_bit;
    enable_nz_next = enable_nz;
    dir_read_next  = dir_read;
    if (fire && clock_enabled) begin
      unique case (in_data.mode)
        MODE_ENABLE: enable_nz_next = |in_data.value;
        MODE_DIR:    dir_read_next  = (in_data.value == DIR_READ);
        MODE_PINS: begin
          if (enable_nz && !dir_read) begin
            // write direction: shift in a command, MSB first
            if (phase == PH_IDLE) begin
              if (sel_b) begin
                phase_next = PH_CMD;
                cmd_next   = 8'h00;
              end
            end else if (phase == PH_CMD && clk_b) begin
              cmd_next = cmd_shifted;
              if (bc_inc[5:3] == 3'd0) begin
                bit_count_next = bc_inc;
              end else begin
                bit_count_next = 6'd0;
                unique case (cmd_shifted)
                  CMD_RESET: phase_next = PH_IDLE;
                  CMD_SKIP: begin
                    phase_next     = PH_SWALLOW;
                    reply_len_next = LEN_STATUS;
                  end
                  CMD_STATUS: begin
                    phase_next     = PH_REPLY;
                    reply_len_next = LEN_STATUS;
                    reply_next[0]  = STATUS_BYTE;
                  end
                  CMD_DATETIME: begin
                    phase_next     = PH_REPLY;
                    reply_len_next = LEN_DATETIME;
                    reply_next     = time_bytes;
                  end
                  CMD_TIME: begin
                    phase_next     = PH_REPLY;
                    reply_len_next = LEN_TIME;
                    reply_next[0]  = time_bytes[4];
                    reply_next[1]  = time_bytes[5];
                    reply_next[2]  = time_bytes[6];
                  end
                  default: ;
                endcase
              end
            end
          end else if (enable_nz) begin
            // read direction: reply bits go out LSB first on pin 1
            if (phase == PH_SWALLOW) begin
              bit_count_next = bc_inc;
              if (bc_inc == target) begin
                bit_count_next = 6'd0;
                phase_next     = PH_IDLE;
              end
            end else begin
              pin_bit_next = cur_byte[bit_count[2:0]];
              if (!clk_b || phase != PH_REPLY) begin
                // select restarts command shift but keeps the bit count
                if (sel_b) begin
                  phase_next = PH_CMD;
                  cmd_next   = 8'h00;
                end
              end else begin
                bit_count_next = bc_inc;
                if (bc_inc == target) begin
                  bit_count_next = 6'd0;
                  phase_next     = PH_IDLE;
                  cmd_next       = 8'h00;
                end
              end
            end
          end
        end
        MODE_NONE: ;
        default: ;
      endcase
    end
  end

  // Result of the accepted transfer
  always_comb begin
    result.data_pins = {6'b000000, pin_bit_next, 1'b0};
    result.phase     = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_enabled <= 1'b1;
      phase         <= PH_IDLE;
      cmd           <= 8'h00;
      bit_count     <= 6'd0;
      reply_len     <= 3'd0;
      reply         <= '0;
      pin_bit       <= 1'b0;
      enable_nz     <= 1'b0;
      dir_read      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        clock_enabled <= cfg_wdata;
      end
      phase     <= phase_next;
      cmd       <= cmd_next;
      bit_count <= bit_count_next;
      reply_len <= reply_len_next;
      reply     <= reply_next;
      pin_bit   <= pin_bit_next;
      enable_nz <= enable_nz_next;
      dir_read  <= dir_read_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload holds until the next accepted transfer
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// File: rtl/srtc_time_enc.sv
// ----------------------------------------------------------------------------
// srtc_time_enc: calendar time to reply bytes
// Converts the binary time fields of a transfer into the BCD byte bank
// loaded by the date/time command; weekday is rebased to Monday first.
// ----------------------------------------------------------------------------
`default_nettype none

module srtc_time_enc
  import srtc_pkg::*;
(
  input  var in_t         item,
  output reply_bank_t     bytes
);

  logic [2:0] weekday_mon;

  // Sunday moves to the end of the week
  assign weekday_mon = (item.weekday == 3'd0) ? 3'd6 : (item.weekday - 3'd1);

  assign bytes[0] = bcd_of(item.year);
  assign bytes[1] = bcd_of({3'b000, item.month});
  assign bytes[2] = bcd_of({2'b00, item.day});
  assign bytes[3] = bcd_of({4'b0000, weekday_mon});
  assign bytes[4] = bcd_of({2'b00, item.hour});
  assign bytes[5] = bcd_of({1'b0, item.minute});
  assign bytes[6] = bcd_of({1'b0, item.second});

endmodule

`default_nettype wire

// File: rtl/srtc_checker.sv
// ----------------------------------------------------------------------------
// srtc_checker: port-level checks for the serial RTC port
// Watches the transfer ports of the top level over time; bound below.
// ----------------------------------------------------------------------------
`default_nettype none

module srtc_checker
  import srtc_pkg::*;
(
  input var logic clk,
  input var logic rst,
  input var logic in_valid,
  input var logic in_ready,
  input var logic out_valid,
  input var logic out_ready,
  input var out_t out_data
);

  // Every accepted input produces a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted input transfer");

  // An empty output register never stalls the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // Only the serial reply bit of the data pins can ever be set
  a_pins_only_bit1: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.data_pins[7:2] == 6'd0 && out_data.data_pins[0] == 1'b0))
    else $error("data pins carry bits other than the reply bit");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind serial_rtc_port_unit srtc_checker u_srtc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// File: verif/serial_rtc_port_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_rtc_port_unit_tb: self-checking bench for the serial RTC port
// Streams bus writes (pin, direction, enable, unmapped) with random calendar
// time into the block. Most writes form bit-banged command and reply sessions,
// and a few are truncated or pure noise. A local model of the RTC protocol
// predicts pins and phase for every write, and each result is checked in
// order. Random gaps and output stalls run across several clock-enable
// settings.
// ----------------------------------------------------------------------------

module serial_rtc_port_unit_tb;
  import srtc_pkg::*;

  localparam int WRITE_GOAL    = 900;
  localparam int PER_SETTING   = 150;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [2:0] SKIP_LEN = 3'd1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  serial_rtc_port_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Model state of the RTC port
  logic       rtc_on;
  phase_t     ph;
  logic [7:0] cmd_sr;
  logic [5:0] bitcnt;
  logic [2:0] rlen;
  logic [7:0] rbytes [REPLY_DEPTH];
  logic [7:0] pins;
  logic [7:0] en_reg;
  logic [7:0] dir_reg;

  in_t  bus_write_q[$];
  out_t port_state_q[$];

  int n_in = 0;
  int n_out = 0;
  int n_err = 0;
  int n_live = 0;
  int n_cmds = 0;
  int n_reads = 0;
  int n_settings = 0;
  int gap_left = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit gap_on = 1'b1;
  bit stall_on = 1'b1;
  out_t want;

  function automatic logic [7:0] to_bcd(int unsigned n);
    logic [7:0] r;
    n = n % 100;
    r[7:4] = 4'(n / 10);
    r[3:0] = 4'(n % 10);
    return r;
  endfunction

  // Write direction: select opens a command, clocked bits fill it MSB first
  function automatic void shift_cmd(logic [7:0] v, in_t it);
    int wd;
    if (ph == PH_IDLE) begin
      if (v[0] && v[2]) begin
        ph = PH_CMD;
        cmd_sr = '0;
      end
      return;
    end
    if (ph != PH_CMD || !v[0]) return;
    // a leftover count of 8 or more drops the bit
    if (bitcnt < 6'd8 && v[1]) cmd_sr[3'd7 - bitcnt[2:0]] = 1'b1;
    bitcnt = bitcnt + 6'd1;
    if (bitcnt < 6'd8) return;
    bitcnt = '0;
    n_cmds++;
    wd = (it.weekday == 3'd0) ? 6 : int'(it.weekday) - 1;
    case (cmd_sr)
      CMD_RESET: ph = PH_IDLE;
      CMD_SKIP: begin
        ph = PH_SWALLOW;
        rlen = SKIP_LEN;
      end
      CMD_STATUS: begin
        rlen = LEN_STATUS;
        rbytes[0] = STATUS_BYTE;
        ph = PH_REPLY;
      end
      CMD_DATETIME: begin
        rlen = LEN_DATETIME;
        rbytes[0] = to_bcd(it.year);
        rbytes[1] = to_bcd(it.month);
        rbytes[2] = to_bcd(it.day);
        rbytes[3] = to_bcd(wd);
        rbytes[4] = to_bcd(it.hour);
        rbytes[5] = to_bcd(it.minute);
        rbytes[6] = to_bcd(it.second);
        ph = PH_REPLY;
      end
      CMD_TIME: begin
        rlen = LEN_TIME;
        rbytes[0] = to_bcd(it.hour);
        rbytes[1] = to_bcd(it.minute);
        rbytes[2] = to_bcd(it.second);
        ph = PH_REPLY;
      end
      default: ; // unknown command: stay in command shift, count restarts
    endcase
  endfunction

  // Read direction: present the current reply bit on pin 1, LSB first
  function automatic void shift_reply(logic [7:0] v);
    logic [5:0] target;
    logic [7:0] rb;
    target = {rlen, 3'b000};
    if (ph == PH_SWALLOW) begin
      bitcnt = bitcnt + 6'd1;
      if (bitcnt == target) begin
        bitcnt = '0;
        ph = PH_IDLE;
      end
      return;
    end
    rb = (bitcnt[5:3] < 3'd7) ? rbytes[bitcnt[5:3]] : 8'h00;
    pins[1] = rb[bitcnt[2:0]];
    if (!v[0] || ph != PH_REPLY) begin
      if (v[0] && v[2]) begin
        ph = PH_CMD;
        cmd_sr = '0;
      end
      return;
    end
    bitcnt = bitcnt + 6'd1;
    if (bitcnt != target) return;
    bitcnt = '0;
    ph = PH_IDLE;
    cmd_sr = '0;
    n_reads++;
  endfunction

  function automatic out_t rtc_port_predict(in_t it);
    out_t r;
    if (rtc_on) begin
      case (it.mode)
        MODE_ENABLE: en_reg = it.value;
        MODE_DIR:    dir_reg = it.value;
        MODE_PINS: begin
          if (en_reg != 8'h00) begin
            if (dir_reg == DIR_READ) shift_reply(it.value);
            else shift_cmd(it.value, it);
          end
        end
        default: ;
      endcase
    end
    r.data_pins = pins;
    r.phase = ph;
    return r;
  endfunction

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [4:0] rand5();
    return 5'($urandom);
  endfunction

  function automatic logic [7:0] write_dir();
    logic [7:0] v;
    v = 8'($urandom);
    if (v == DIR_READ) v = 8'h00;
    return v;
  endfunction

  task automatic put(mode_t m, logic [7:0] v);
    in_t it;
    int sel;
    sel = $urandom_range(0, 7);
    it.mode = m;
    it.value = v;
    if (sel == 0) begin
      it.year = 7'd0;  it.month = 4'd1;  it.day = 5'd1;  it.weekday = 3'd0;
      it.hour = 5'd0;  it.minute = 6'd0; it.second = 6'd0;
    end else if (sel == 1) begin
      it.year = 7'd99; it.month = 4'd12; it.day = 5'd31; it.weekday = 3'd6;
      it.hour = 5'd23; it.minute = 6'd59; it.second = 6'd59;
    end else begin
      it.year    = 7'($urandom_range(0, 99));
      it.month   = 4'($urandom_range(1, 12));
      it.day     = 5'($urandom_range(1, 31));
      it.weekday = 3'($urandom_range(0, 6));
      it.hour    = 5'($urandom_range(0, 23));
      it.minute  = 6'($urandom_range(0, 59));
      it.second  = 6'($urandom_range(0, 59));
    end
    bus_write_q.push_back(it);
    n_live++;
  endtask

  // One serial clock: optional low phase, then the rising write
  task automatic clock_bit(logic d, logic sel, bit slow);
    if (slow) put(MODE_PINS, {rand5(), sel, d, 1'b0});
    put(MODE_PINS, {rand5(), sel, d, 1'b1});
    if ($urandom_range(0, 15) == 0) put(MODE_NONE, 8'($urandom));
  endtask

  task automatic settle();
    while (bus_write_q.size() != 0 || in_valid || port_state_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_rtc_enable(logic on);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk);
    cfg_we <= 1'b0;
    rtc_on = on;
    n_settings++;
  endtask

  task automatic run_session(bit broken);
    int kind;
    int nbits;
    int nread;
    int k;
    int span;
    bit slow;
    logic [7:0] code;
    kind = $urandom_range(0, 5);
    slow = 1'($urandom_range(0, 1));
    span = 0;
    case (kind)
      0: begin code = CMD_STATUS;   span = 8;  end
      1: begin code = CMD_TIME;     span = 24; end
      2: begin code = CMD_DATETIME; span = 56; end
      3: begin code = CMD_SKIP;     span = 8;  end
      4: code = CMD_RESET;
      default: begin
        do code = 8'($urandom);
        while (code == CMD_RESET || code == CMD_SKIP || code == CMD_STATUS ||
               code == CMD_DATETIME || code == CMD_TIME);
      end
    endcase
    if ($urandom_range(0, 3) == 0) put(MODE_ENABLE, 8'($urandom_range(1, 255)));
    put(MODE_DIR, write_dir());
    put(MODE_PINS, {rand5(), 3'b101});
    nbits = broken ? $urandom_range(0, 7) : 8;
    for (k = 0; k < nbits; k++) clock_bit(code[7 - k], 1'b1, slow);
    // unknown command leaves the shifter armed: close it with a reset command
    if (kind == 5 && !broken)
      for (k = 0; k < 8; k++) clock_bit(CMD_RESET[7 - k], 1'b1, slow);
    if (span != 0 && nbits == 8) begin
      put(MODE_DIR, DIR_READ);
      nread = broken ? $urandom_range(0, span - 1) : span;
      // swallow counts every pin write, so no low phases there
      for (k = 0; k < nread; k++)
        clock_bit(1'($urandom_range(0, 1)), 1'b0, slow && kind != 3);
    end
    if (broken) begin
      put(MODE_DIR, $urandom_range(0, 1) ? DIR_READ : 8'h00);
      repeat ($urandom_range(1, 4)) put(MODE_PINS, 8'($urandom));
    end
  endtask

  // Drive the port back to idle from whatever state the model holds now
  task automatic recover();
    int k;
    int zeros;
    if (!rtc_on) return;
    if (en_reg == 8'h00) put(MODE_ENABLE, 8'($urandom_range(1, 255)));
    if (ph == PH_REPLY || ph == PH_SWALLOW) begin
      put(MODE_DIR, DIR_READ);
      for (k = int'(bitcnt); k < 8 * rlen; k++)
        put(MODE_PINS, {rand5(), 1'b0, 1'($urandom), 1'b1});
    end else if (ph == PH_CMD) begin
      put(MODE_DIR, DIR_READ);
      put(MODE_PINS, {rand5(), 1'b1, 1'($urandom), 1'b1});
      put(MODE_DIR, write_dir());
      zeros = (bitcnt >= 6'd8) ? 1 : ((bitcnt == 6'd0) ? 0 : 8 - int'(bitcnt));
      for (k = 0; k < zeros; k++) put(MODE_PINS, {rand5(), 1'($urandom), 1'b0, 1'b1});
      for (k = 0; k < 8; k++) put(MODE_PINS, {rand5(), 1'($urandom), CMD_RESET[7 - k], 1'b1});
    end
  endtask

  task automatic flag(string msg);
    n_err++;
    if (n_err <= 10) $display("MISMATCH: %s", msg);
  endtask

  // Driver: hold a write until it transfers, then advance to the next one
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        port_state_q.push_back(rtc_port_predict(in_data));
        n_in++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (bus_write_q.size() != 0) begin
          in_data <= bus_write_q.pop_front();
          in_valid <= 1'b1;
          if (gap_on && $urandom_range(0, 3) == 0) gap_left = pause_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        n_out++;
        if (port_state_q.size() == 0) begin
          flag($sformatf("result %0d with none pending: pins=%02h phase=%0d",
                         n_out, out_data.data_pins, out_data.phase));
        end else begin
          want = port_state_q.pop_front();
          if (out_data.data_pins !== want.data_pins || out_data.phase !== want.phase)
            flag($sformatf("result %0d: expected pins=%02h phase=%0d, got pins=%02h phase=%0d",
                           n_out, want.data_pins, want.phase,
                           out_data.data_pins, out_data.phase));
        end
      end
      if (stall_left != 0) stall_left--;
      else if (stall_on && $urandom_range(0, 3) == 0) stall_left = pause_len();
      out_ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("serial_rtc_port_unit verification failed");
      $finish;
    end
  end

  initial begin
    int k;
    int setting_no;
    int goal;
    bit broken;
    rtc_on = 1'b1;
    ph = PH_IDLE;
    cmd_sr = '0;
    bitcnt = '0;
    rlen = '0;
    for (k = 0; k < REPLY_DEPTH; k++) rbytes[k] = '0;
    pins = '0;
    en_reg = '0;
    dir_reg = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_rtc_enable(1'b1);

    // Directed: ignored writes, every register, then a status read-out
    put(MODE_PINS, 8'hFF);
    put(MODE_NONE, 8'hFF);
    put(MODE_ENABLE, 8'h00);
    put(MODE_ENABLE, 8'hFF);
    put(MODE_DIR, 8'h00);
    put(MODE_PINS, 8'h05);
    for (k = 0; k < 8; k++) put(MODE_PINS, {5'h1F, 1'b1, CMD_STATUS[7 - k], 1'b1});
    put(MODE_DIR, DIR_READ);
    for (k = 0; k < 8; k++) put(MODE_PINS, 8'h01);
    settle();
    recover();

    setting_no = 0;
    while (n_live < WRITE_GOAL) begin
      set_rtc_enable(setting_no % 3 != 2);
      gap_on = (setting_no % 4 != 1);
      stall_on = (setting_no % 4 != 1);
      if (rtc_on) begin
        goal = n_live + PER_SETTING;
        while (n_live < goal) begin
          if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(4, 16)) put(mode_t'($urandom_range(0, 3)), 8'($urandom));
            broken = 1'b1;
          end else begin
            broken = ($urandom_range(0, 9) == 0);
            run_session(broken);
          end
          if (broken) begin
            settle();
            recover();
          end
        end
      end else begin
        repeat (3) run_session(1'($urandom_range(0, 1)));
      end
      setting_no++;
    end

    settle();
    repeat (4) @(posedge clk);
    if (port_state_q.size() != 0)
      flag($sformatf("%0d results never arrived", port_state_q.size()));
    $display("Checked %0d bus writes over %0d clock-enable settings,", n_in, n_settings);
    $display("with %0d commands decoded and %0d replies shifted out.", n_cmds, n_reads);
    if (n_err == 0) begin
      $display("serial_rtc_port_unit verification clean");
    end else begin
      $display("serial_rtc_port_unit verification failed");
    end
    $finish;
  end

endmodule
